@@ sv/spc_pkg.sv @@
// Shared types, constants and per-byte CRC-32 / UTF-8 step functions for the section checker.
package spc_pkg;

   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
   localparam logic [20:0] CP_MAX     = 21'h10_FFFF;
   localparam logic [20:0] SURR_LO    = 21'h00_D800;
   localparam logic [20:0] SURR_HI    = 21'h00_DFFF;

   localparam logic [1:0] MIN_CLASS_NONE  = 2'd0;
   localparam logic [1:0] MIN_CLASS_TWO   = 2'd1;
   localparam logic [1:0] MIN_CLASS_THREE = 2'd2;
   localparam logic [1:0] MIN_CLASS_FOUR  = 2'd3;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_CRC_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_BAD_UTF8     = 2'd2;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [31:0] expected_crc;
      logic        check_utf8;
   } item_type;

   typedef struct packed {
      logic [1:0]  pending;
      logic [20:0] partial;
      logic [1:0]  min_class;
      logic        error;
   } utf8_type;

   localparam utf8_type UTF8_IDLE = '0;

   function automatic logic [20:0] class_minimum(input logic [1:0] min_class);
      logic [20:0] m;
      case (min_class)
         MIN_CLASS_NONE:  m = 21'h00_0000;
         MIN_CLASS_TWO:   m = 21'h00_0080;
         MIN_CLASS_THREE: m = 21'h00_0800;
         default:         m = 21'h01_0000;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h00_0000, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

   function automatic utf8_type utf8_step(input utf8_type s, input logic [7:0] b);
      utf8_type    n;
      logic [20:0] cp;
      logic [1:0]  left;
      n    = s;
      cp   = {s.partial[14:0], b[5:0]};
      left = s.pending - 2'd1;
      if (!s.error) begin
         if (s.pending == 2'd0) begin
            // plain ASCII leaves the decoder untouched
            if (b[7]) begin
               if (b[7:5] == 3'b110) begin
                  n.pending   = 2'd1;
                  n.partial   = {16'h0000, b[4:0]};
                  n.min_class = MIN_CLASS_TWO;
               end else if (b[7:4] == 4'b1110) begin
                  n.pending   = 2'd2;
                  n.partial   = {17'h0_0000, b[3:0]};
                  n.min_class = MIN_CLASS_THREE;
               end else if (b[7:3] == 5'b11110) begin
                  n.pending   = 2'd3;
                  n.partial   = {18'h0_0000, b[2:0]};
                  n.min_class = MIN_CLASS_FOUR;
               end else begin
                  n.error = 1'b1;
               end
            end
         end else if (b[7:6] != 2'b10) begin
            n.error = 1'b1;
         end else begin
            n.partial = cp;
            n.pending = left;
            if (left == 2'd0) begin
               // sequence complete: reject overlong, out of range and surrogates
               if (cp < class_minimum(s.min_class) || cp > CP_MAX ||
                   (cp >= SURR_LO && cp <= SURR_HI)) begin
                  n.error = 1'b1;
               end
               n.partial   = '0;
               n.min_class = MIN_CLASS_NONE;
            end
         end
      end
      return n;
   endfunction

endpackage

@@ sv/spc_in_stage.sv @@
// Input register: holds one byte beat and its marks until the checker core takes it.
module spc_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  spc_pkg::item_type   req_item,
   input  logic                take,
   output logic                item_valid,
   output spc_pkg::item_type   item
);
   import spc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   logic     load;
   item_type item_ff;

   always_comb begin
      req_ready = !valid_ff || take;
      load      = req_valid && req_ready;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ sv/spc_core.sv @@
// Checker core: running CRC-32 and UTF-8 decoder state, verdict on the last byte, result register.
module spc_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  spc_pkg::item_type  item,
   output logic               take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         check_status,
   output logic [31:0]        computed_crc
);
   import spc_pkg::*;

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   utf8_type    utf8_ff;
   utf8_type    utf8_in;
   logic        rsp_valid_ff;
   logic [1:0]  status_ff;
   logic [1:0]  status_in;
   logic [31:0] result_crc_ff;
   logic [31:0] result_crc_in;
   logic        out_free;
   logic        finish;

   always_comb begin
      // a first-byte mark restarts both checks before this byte
      crc_in        = crc32_byte(item.first_byte ? CRC_PRESET : crc_ff, item.data_byte);
      utf8_in       = utf8_step(item.first_byte ? UTF8_IDLE : utf8_ff, item.data_byte);
      result_crc_in = ~crc_in;
      if (result_crc_in != item.expected_crc) begin
         status_in = STATUS_CRC_MISMATCH;
      end else if (item.check_utf8 && (utf8_in.error || utf8_in.pending != 2'd0)) begin
         status_in = STATUS_BAD_UTF8;
      end else begin
         status_in = STATUS_OK;
      end
      out_free = !rsp_valid_ff || rsp_ready;
      // only a last byte needs room in the result register
      take     = item_valid && (!item.last_byte || out_free);
      finish   = take && item.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_PRESET;
         utf8_ff      <= UTF8_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish) begin
            crc_ff  <= CRC_PRESET;
            utf8_ff <= UTF8_IDLE;
         end else if (take) begin
            crc_ff  <= crc_in;
            utf8_ff <= utf8_in;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff     <= status_in;
         result_crc_ff <= result_crc_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign check_status = status_ff;
   assign computed_crc = result_crc_ff;

endmodule

@@ sv/section_payload_checker_top.sv @@
// Top level of the section payload checker: stream ports, input register and checker core.
//
//   channel  | direction | tdata (low bit up)                      | side band
//   ---------+-----------+-----------------------------------------+----------------------------
//   req_     | in        | data_byte[7:0], expected_crc[39:8]      | tlast last_byte, tuser
//            |           |                                         | first_byte[0], check_utf8[1]
//   rsp_     | out       | check_status[1:0], computed_crc[33:2]   | -
//
// One byte beat per cycle. A beat is captured in the input register, then the CRC-32
// byte update and the UTF-8 decoder step run combinationally into the state and result
// registers, so a section's result is on rsp_ once the core has taken its last beat.
// Synchronous reset clears the CRC to all ones and the decoder to idle; no clearing pass.
// A stalled result holds only beats that end a section; other beats keep flowing.
module section_payload_checker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], expected_crc[39:8]
   input  logic        req_tlast,
   input  logic [1:0]  req_tuser,   // first_byte[0], check_utf8[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // check_status[1:0], computed_crc[33:2], zero[39:34]
);
   import spc_pkg::*;

   item_type    req_item;
   item_type    item;
   logic        item_valid;
   logic        take;
   logic [1:0]  check_status;
   logic [31:0] computed_crc;

   always_comb begin
      req_item.data_byte    = req_tdata[7:0];
      req_item.first_byte   = req_tuser[0];
      req_item.last_byte    = req_tlast;
      req_item.expected_crc = req_tdata[39:8];
      req_item.check_utf8   = req_tuser[1];
   end

   spc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   spc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .take         (take),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .check_status (check_status),
      .computed_crc (computed_crc)
   );

   assign rsp_tdata = {6'b00_0000, computed_crc, check_status};

endmodule

@@ test/section_verdict_checker.sv @@
// Section verdict checker: CRC-32 helper plus a monitor that predicts and compares each verdict.
`timescale 1ns / 100ps

package section_crc_pkg;
   import spc_pkg::*;

   // Bit-serial reflected CRC-32: fold in one data bit per shift.
   function automatic logic [31:0] crc32_advance(input logic [31:0] crc, input logic [7:0] octet);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ octet[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction
endpackage

module section_verdict_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], expected_crc[39:8]
   input  logic        req_tlast,
   input  logic [1:0]  req_tuser,   // first_byte[0], check_utf8[1]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // check_status[1:0], computed_crc[33:2]
   output int          fail_count,
   output int          pending_results
);
   import spc_pkg::*;
   import section_crc_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] crc;
   } verdict_type;

   verdict_type verdict_queue[$];
   logic [31:0] crc_state;
   logic [1:0]  cont_left;
   logic [20:0] code_acc;
   logic [1:0]  code_class;
   logic        utf8_bad;
   int          fail_total = 0;

   assign fail_count = fail_total;

   task automatic clear_section();
      crc_state  = CRC_PRESET;
      cont_left  = 2'd0;
      code_acc   = '0;
      code_class = MIN_CLASS_NONE;
      utf8_bad   = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [39:0] got,
                                  input logic [39:0] want);
      $display("%0t ns: %s wrong: got %h, want %h", $time, what, got, want);
      fail_total++;
   endtask

   task automatic decode_octet(input logic [7:0] octet);
      logic [20:0] lowest;
      if (utf8_bad) begin
         // sticky: ignore the rest of the section
      end else if (cont_left == 2'd0) begin
         if (octet[7:5] == 3'b110) begin
            cont_left  = 2'd1;
            code_acc   = {16'd0, octet[4:0]};
            code_class = MIN_CLASS_TWO;
         end else if (octet[7:4] == 4'b1110) begin
            cont_left  = 2'd2;
            code_acc   = {17'd0, octet[3:0]};
            code_class = MIN_CLASS_THREE;
         end else if (octet[7:3] == 5'b11110) begin
            cont_left  = 2'd3;
            code_acc   = {18'd0, octet[2:0]};
            code_class = MIN_CLASS_FOUR;
         end else if (octet[7]) begin
            utf8_bad = 1'b1;
         end
      end else if (octet[7:6] != 2'b10) begin
         utf8_bad = 1'b1;
      end else begin
         code_acc  = {code_acc[14:0], octet[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            case (code_class)
               MIN_CLASS_TWO:   lowest = 21'h00_0080;
               MIN_CLASS_THREE: lowest = 21'h00_0800;
               MIN_CLASS_FOUR:  lowest = 21'h01_0000;
               default:         lowest = 21'h00_0000;
            endcase
            // reject overlong forms, values past the top and surrogates
            if (code_acc < lowest || code_acc > CP_MAX ||
                (code_acc >= SURR_LO && code_acc <= SURR_HI)) begin
               utf8_bad = 1'b1;
            end
            code_acc   = '0;
            code_class = MIN_CLASS_NONE;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      verdict_type want;
      verdict_type fresh;
      logic [31:0] final_crc;
      if (reset) begin
         clear_section();
         verdict_queue.delete();
      end else begin
         // check results before taking new beats: a verdict never leaves on its own beat
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, '0);
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_tdata[1:0] != want.status) begin
                  report_mismatch("check_status", 40'(rsp_tdata[1:0]), 40'(want.status));
               end
               if (rsp_tdata[33:2] != want.crc) begin
                  report_mismatch("computed_crc", 40'(rsp_tdata[33:2]), 40'(want.crc));
               end
               if (rsp_tdata[39:34] != '0) begin
                  report_mismatch("tdata padding", 40'(rsp_tdata[39:34]), '0);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0]) begin
               clear_section();
            end
            crc_state = crc32_advance(crc_state, req_tdata[7:0]);
            decode_octet(req_tdata[7:0]);
            if (req_tlast) begin
               final_crc = ~crc_state;
               if (final_crc != req_tdata[39:8]) begin
                  fresh.status = STATUS_CRC_MISMATCH;
               end else if (req_tuser[1] && (utf8_bad || cont_left != 2'd0)) begin
                  fresh.status = STATUS_BAD_UTF8;
               end else begin
                  fresh.status = STATUS_OK;
               end
               fresh.crc = final_crc;
               verdict_queue.push_back(fresh);
               clear_section();
            end
         end
      end
      pending_results <= verdict_queue.size();
   end

endmodule

@@ test/testbench.sv @@
// Testbench top: drives section byte streams into the payload checker and gives the verdict.
`timescale 1ns / 100ps

module testbench;
   import spc_pkg::*;
   import section_crc_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_BEATS = 500;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [39:0] req_tdata  = '0;   // data_byte[7:0], expected_crc[39:8]
   logic        req_tlast  = 1'b0;
   logic [1:0]  req_tuser  = '0;   // first_byte[0], check_utf8[1]
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [39:0] rsp_tdata;        // check_status[1:0], computed_crc[33:2]

   int          fail_count;
   int          pending_results;
   int          send_idle_pct = 38;
   int          recv_idle_pct = 76;
   int          quiet_cycles  = 0;
   int          beats_sent    = 0;
   int          sections_sent = 0;
   logic [7:0]  section_bytes[$];

   section_payload_checker_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   section_verdict_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
         $display("section_payload_checker_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic [7:0] octet, input logic first, input logic last,
                            input logic [31:0] stored_crc, input logic check);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stored_crc, octet};
      req_tlast  <= last;
      req_tuser  <= {check, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // Send section_bytes as one section; the stored CRC is the true one unless told otherwise.
   task automatic send_section(input bit head_first, input int restart_at, input bit check,
                               input bit wrong_crc, input logic [31:0] wrong_value);
      logic [31:0] run_crc;
      logic        first;
      logic        last;
      logic [31:0] stored;
      run_crc = CRC_PRESET;
      foreach (section_bytes[i]) begin
         first = (i == 0 && head_first) || i == restart_at;
         last  = (i == section_bytes.size() - 1);
         if (first) begin
            run_crc = CRC_PRESET;
         end
         run_crc = crc32_advance(run_crc, section_bytes[i]);
         stored  = last ? (wrong_crc ? wrong_value : ~run_crc) : $urandom;
         send_beat(section_bytes[i], first, last, stored, check);
      end
      sections_sent++;
   endtask

   // Hold the sender until every verdict owed has come back.
   task automatic wait_for_verdicts();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic push_codepoint(input logic [20:0] cp, input int len);
      case (len)
         1: section_bytes.push_back({1'b0, cp[6:0]});
         2: begin
            section_bytes.push_back({3'b110, cp[10:6]});
            section_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            section_bytes.push_back({4'b1110, cp[15:12]});
            section_bytes.push_back({2'b10, cp[11:6]});
            section_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            section_bytes.push_back({5'b11110, cp[20:18]});
            section_bytes.push_back({2'b10, cp[17:12]});
            section_bytes.push_back({2'b10, cp[11:6]});
            section_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // Mostly well-formed text, with a share of broken sequences mixed in.
   task automatic build_section();
      int          pick;
      logic [20:0] cp;
      section_bytes.delete();
      repeat ($urandom_range(6, 1)) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            push_codepoint(21'($urandom_range(8'h7f)), 1);
         end else if (pick < 50) begin
            push_codepoint(21'($urandom_range(21'h7ff, 21'h80)), 2);
         end else if (pick < 68) begin
            cp = 21'($urandom_range(21'hffff, 21'h800));
            if (cp >= SURR_LO && cp <= SURR_HI) begin
               cp = cp ^ 21'h1000;
            end
            push_codepoint(cp, 3);
         end else if (pick < 84) begin
            push_codepoint(21'($urandom_range(21'h10ffff, 21'h10000)), 4);
         end else begin
            case ($urandom_range(6))
               0: section_bytes.push_back(8'($urandom_range(255)));
               1: push_codepoint(21'($urandom_range(8'h7f)), 2);
               2: push_codepoint(21'($urandom_range(21'h7ff)), 3);
               3: push_codepoint(21'($urandom_range(21'hffff)), 4);
               4: push_codepoint(21'($urandom_range(SURR_HI, SURR_LO)), 3);
               5: push_codepoint(21'($urandom_range(21'h1fffff, 21'h110000)), 4);
               default: begin
                  // cut short: the next lead byte or the section end finds it open
                  push_codepoint(21'($urandom_range(21'h10ffff, 21'h10000)), 4);
                  repeat ($urandom_range(3, 1)) void'(section_bytes.pop_back());
               end
            endcase
         end
      end
   endtask

   initial begin
      int base;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // one-byte sections: both marks on one beat
      section_bytes = '{8'h00};
      send_section(1, -1, 1, 0, '0);
      section_bytes = '{8'hff};
      send_section(1, -1, 1, 0, '0);
      // crc mismatch wins over a bad lead byte
      section_bytes = '{8'hfe};
      send_section(1, -1, 1, 1, 32'h0000_0000);
      // truncated sequence at the section end
      section_bytes = '{8'he2, 8'h82};
      send_section(1, -1, 1, 0, '0);
      // overlong form with checking off
      section_bytes = '{8'hc0, 8'h80};
      send_section(1, -1, 0, 0, '0);
      // error stays set through a later valid character
      section_bytes = '{8'h80, 8'hc3, 8'ha9};
      send_section(1, -1, 1, 0, '0);
      // no first mark: previous last beat already restarted everything
      section_bytes = '{8'hf0, 8'h9f, 8'h98, 8'h80};
      send_section(0, -1, 1, 0, '0);
      // restart mid-section drops the open sequence
      section_bytes = '{8'he2, 8'h24};
      send_section(1, 1, 1, 0, '0);
      // surrogate, then a value past the top of the range
      section_bytes = '{8'hed, 8'ha0, 8'h80};
      send_section(1, -1, 1, 0, '0);
      section_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};
      send_section(1, -1, 1, 0, '0);
      wait_for_verdicts();

      base = beats_sent;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 76 : 0;
         recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 38 : 0;
         while (beats_sent < base + (phase + 1) * RANDOM_BEATS / 3) begin
            build_section();
            send_section($urandom_range(9) != 0,
                         ($urandom_range(14) == 0) ? $urandom_range(section_bytes.size() - 1)
                                                   : -1,
                         $urandom_range(3) != 0, $urandom_range(4) == 0, $urandom);
         end
         wait_for_verdicts();
      end
      repeat (8) @(posedge clock);

      $display("run: %0d byte beats in %0d sections, corner sections then random UTF-8 text",
               beats_sent, sections_sent);
      $display("run: sender-heavy, receiver-heavy and stall-free phases, drained between");
      if (fail_count == 0) begin
         $display("section_payload_checker_top: match");
      end else begin
         $display("section_payload_checker_top: mismatch");
      end
      $finish;
   end

endmodule
